@@ hdl/aes_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// AES package
// Shared types, register indexes, substitution tables and GF(2^8) helpers.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int MaxRounds  = 12;
    localparam int StoreWords = 4 * (MaxRounds + 1);
    localparam int AddrW      = $clog2(StoreWords);
    localparam int RoundW     = $clog2(MaxRounds + 1);

    // configuration register indexes
    localparam logic [1:0] REG_KEY_LENGTH = 2'd0;
    localparam logic [1:0] REG_KEY_0_7    = 2'd1;
    localparam logic [1:0] REG_KEY_8_15   = 2'd2;
    localparam logic [1:0] REG_KEY_16_23  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_CIPHER,
        ST_DONE
    } t_state;

    typedef logic [7:0]   t_byte;
    typedef logic [127:0] t_block;

    function automatic t_byte sbox_fwd(input t_byte a);
        t_byte r;
        unique case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // inverse S-box found as the index whose forward image matches
    function automatic t_byte sbox_inv(input t_byte a);
        t_byte r;
        r = 8'h00;
        for (int i = 0; i < 256; i++) begin
            if (sbox_fwd(t_byte'(i)) == a) begin
                r = t_byte'(i);
            end
        end
        return r;
    endfunction

    function automatic t_byte xtime(input t_byte v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_byte rcon(input logic [3:0] i);
        t_byte r;
        unique case (i)
            4'd0: r = 8'h01; 4'd1: r = 8'h02; 4'd2: r = 8'h04; 4'd3: r = 8'h08;
            4'd4: r = 8'h10; 4'd5: r = 8'h20; 4'd6: r = 8'h40; 4'd7: r = 8'h80;
            4'd8: r = 8'h1b; 4'd9: r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hdl/aes_block_cipher_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// AES block cipher unit
// AES-128/192 encrypt and decrypt with a round-key memory and a shared round.
// ----------------------------------------------------------------------------
// One transaction at a time; busy is high until the result shows.
// A key-register write while idle or expanding runs a key expansion of
// 4*(rounds+1) words, one word per cycle through the round-key memory write
// port, with busy held high. A block sent before any key write returns zero.
// Reset clears the key registers and the key-ready flag.
module aes_block_cipher_unit
    import aes_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [4:0]   paddr,
    input  wire  [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  wire          start,
    output logic         busy,
    input  wire          i_operation,
    input  wire  [63:0]  i_block_hi,
    input  wire  [63:0]  i_block_lo,
    output logic         o_valid,
    output logic [63:0]  o_result_hi,
    output logic [63:0]  o_result_lo
);

    t_state r_state, n_state;
    logic        r_key_length;
    logic [63:0] r_key0, r_key1, r_key2;
    logic        r_keys_ready;
    logic [5:0]  r_idx;
    logic [2:0]  r_j;
    logic [3:0]  r_rci;
    logic [31:0] r_kw [6];
    logic [RoundW-1:0] r_round;
    logic        r_dec;
    t_block      r_block;
    logic        r_first;

    logic        cfg_wr;
    logic [1:0]  cfg_reg;
    logic [3:0]  nrounds;
    logic [2:0]  nk;
    logic [5:0]  total;
    logic [31:0] new_word;
    logic        ks_we;
    logic [1:0]  ks_wsel;
    logic [RoundW-1:0] ks_wrow;
    logic [RoundW-1:0] ks_rrow;
    logic [127:0] ks_rdata;
    t_block      rnd_out;
    logic        last_round;

    assign pready  = 1'b1;
    assign cfg_reg = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite;
    assign nrounds = r_key_length ? 4'd12 : 4'd10;
    assign nk      = r_key_length ? 3'd6 : 3'd4;
    assign total   = r_key_length ? 6'd52 : 6'd44;
    // a key write in progress holds off a new transaction
    assign busy    = (r_state != ST_IDLE) || cfg_wr;

    // register read-back
    always_comb begin
        unique case (cfg_reg)
            REG_KEY_LENGTH: prdata = {63'd0, r_key_length};
            REG_KEY_0_7:    prdata = r_key0;
            REG_KEY_8_15:   prdata = r_key1;
            REG_KEY_16_23:  prdata = r_key2;
            default:        prdata = 64'd0;
        endcase
    end

    // key schedule word: sliding window of the last nk words
    always_comb begin
        logic [31:0] t;
        logic [31:0] rot;
        t   = r_kw[nk-3'd1];
        rot = {t[23:0], t[31:24]};
        new_word = r_kw[0] ^ t;
        if (r_idx < {3'd0, nk}) begin
            new_word = r_kw[r_idx[2:0]];
        end else if (r_j == 3'd0) begin
            new_word = r_kw[0] ^ ({sbox_fwd(rot[31:24]), sbox_fwd(rot[23:16]),
                                   sbox_fwd(rot[15:8]), sbox_fwd(rot[7:0])}
                                  ^ {rcon(r_rci), 24'd0});
        end
    end

    assign ks_we   = (r_state == ST_EXPAND);
    assign ks_wsel = r_idx[1:0];
    assign ks_wrow = RoundW'(r_idx[5:2]);

    // next round key row: rounds counted in key order
    assign last_round = r_dec ? (r_round == RoundW'(0))
                              : (r_round == RoundW'(nrounds));
    always_comb begin
        ks_rrow = r_round;
        if (start && !busy) begin
            ks_rrow = i_operation ? RoundW'(nrounds) : RoundW'(0);
        end else if (r_state == ST_CIPHER) begin
            ks_rrow = r_dec ? r_round - RoundW'(1) : r_round + RoundW'(1);
        end
    end

    aes_key_store u_store (
        .i_clk   (i_clk),
        .i_we    (ks_we),
        .i_wsel  (ks_wsel),
        .i_wrow  (ks_wrow),
        .i_wdata (new_word),
        .i_rrow  (ks_rrow),
        .o_rdata (ks_rdata)
    );

    aes_round u_round (
        .i_state   (r_block),
        .i_decrypt (r_dec),
        .i_mix     (!last_round),
        .i_key     (ks_rdata),
        .o_state   (rnd_out)
    );

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (cfg_wr) begin
                    n_state = ST_EXPAND;
                end else if (start) begin
                    n_state = r_keys_ready ? ST_CIPHER : ST_DONE;
                end
            end
            // a further key write restarts the expansion
            ST_EXPAND: begin
                if (cfg_wr) begin
                    n_state = ST_EXPAND;
                end else if (r_idx == total - 6'd1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CIPHER: if (!r_first && last_round) n_state = ST_DONE;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // configuration registers and key-ready flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= 1'b0;
            r_key0       <= 64'd0;
            r_key1       <= 64'd0;
            r_key2       <= 64'd0;
            r_keys_ready <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_reg)
                    REG_KEY_LENGTH: r_key_length <= pwdata[0];
                    REG_KEY_0_7:    r_key0 <= pwdata;
                    REG_KEY_8_15:   r_key1 <= pwdata;
                    REG_KEY_16_23:  r_key2 <= pwdata;
                    default: ;
                endcase
            end
            if (r_state == ST_EXPAND && n_state == ST_IDLE) begin
                r_keys_ready <= 1'b1;
            end
        end
    end

    // expansion counters and word window
    always_ff @(posedge i_clk) begin
        if (cfg_wr && (r_state == ST_IDLE || r_state == ST_EXPAND)) begin
            r_idx <= 6'd0;
            r_j   <= 3'd0;
            r_rci <= 4'd0;
            r_kw[0] <= (cfg_reg == REG_KEY_0_7) ? pwdata[63:32] : r_key0[63:32];
            r_kw[1] <= (cfg_reg == REG_KEY_0_7) ? pwdata[31:0]  : r_key0[31:0];
            r_kw[2] <= (cfg_reg == REG_KEY_8_15) ? pwdata[63:32] : r_key1[63:32];
            r_kw[3] <= (cfg_reg == REG_KEY_8_15) ? pwdata[31:0]  : r_key1[31:0];
            r_kw[4] <= (cfg_reg == REG_KEY_16_23) ? pwdata[63:32] : r_key2[63:32];
            r_kw[5] <= (cfg_reg == REG_KEY_16_23) ? pwdata[31:0]  : r_key2[31:0];
        end else if (r_state == ST_EXPAND) begin
            r_idx <= r_idx + 6'd1;
            if (r_idx >= {3'd0, nk}) begin
                // shift the window down and append the new word
                for (int k = 0; k < 5; k++) begin
                    r_kw[k] <= (k == int'(nk) - 1) ? new_word : r_kw[k+1];
                end
                if (nk == 3'd6) r_kw[5] <= new_word;
                r_j <= (r_j == nk - 3'd1) ? 3'd0 : r_j + 3'd1;
                if (r_j == 3'd0) r_rci <= r_rci + 4'd1;
            end
        end
    end

    // cipher datapath
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_block <= {i_block_hi, i_block_lo};
            r_dec   <= i_operation;
            r_round <= i_operation ? RoundW'(nrounds) : RoundW'(0);
            r_first <= 1'b1;
        end else if (r_state == ST_CIPHER) begin
            r_first <= 1'b0;
            if (r_first) begin
                r_block <= r_block ^ ks_rdata;
            end else begin
                r_block <= rnd_out;
            end
            r_round <= ks_rrow;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= (r_state == ST_DONE);
        end
    end
    assign o_result_hi = r_keys_ready ? r_block[127:64] : 64'd0;
    assign o_result_lo = r_keys_ready ? r_block[63:0]   : 64'd0;

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than a cycle");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CIPHER) |-> busy) else $error("busy low mid cipher");
    a_expand_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXPAND) |-> (r_idx < total)) else $error("expansion overrun");

endmodule
`default_nettype wire

@@ hdl/aes_round.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// AES round unit
// One full forward or inverse round on a 128-bit state in one pass.
// ----------------------------------------------------------------------------
module aes_round
    import aes_pkg::*;
(
    input  wire  t_block i_state,
    input  wire          i_decrypt,
    input  wire          i_mix,
    input  wire  t_block i_key,
    output t_block       o_state
);

    t_block sb_out;
    t_block sr_out;
    t_block mc_out;

    function automatic t_byte m9(input t_byte v);
        return xtime(xtime(xtime(v))) ^ v;
    endfunction
    function automatic t_byte m11(input t_byte v);
        return xtime(xtime(xtime(v))) ^ xtime(v) ^ v;
    endfunction
    function automatic t_byte m13(input t_byte v);
        return xtime(xtime(xtime(v))) ^ xtime(xtime(v)) ^ v;
    endfunction
    function automatic t_byte m14(input t_byte v);
        return xtime(xtime(xtime(v))) ^ xtime(xtime(v)) ^ xtime(v);
    endfunction

    function automatic t_block inv_mix_of(input t_block s);
        t_block o;
        t_byte a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127-32*c -: 8];
            a1 = s[119-32*c -: 8];
            a2 = s[111-32*c -: 8];
            a3 = s[103-32*c -: 8];
            o[127-32*c -: 8] = m14(a0) ^ m11(a1) ^ m13(a2) ^ m9(a3);
            o[119-32*c -: 8] = m9(a0)  ^ m14(a1) ^ m11(a2) ^ m13(a3);
            o[111-32*c -: 8] = m13(a0) ^ m9(a1)  ^ m14(a2) ^ m11(a3);
            o[103-32*c -: 8] = m11(a0) ^ m13(a1) ^ m9(a2)  ^ m14(a3);
        end
        return o;
    endfunction

    // substitute each byte; order of sub and shift is immaterial
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            sb_out[127-8*i -: 8] = i_decrypt ? sbox_inv(i_state[127-8*i -: 8])
                                             : sbox_fwd(i_state[127-8*i -: 8]);
        end
    end

    // shift rows: byte 4c+r takes from column (c +/- r) mod 4
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sr_out[127-8*(4*c+r) -: 8] = i_decrypt
                    ? sb_out[127-8*(4*((c+4-r)%4)+r) -: 8]
                    : sb_out[127-8*(4*((c+r)%4)+r) -: 8];
            end
        end
    end

    // mix columns, forward or inverse
    always_comb begin
        t_byte a [4];
        t_byte x2 [4];
        t_byte x4 [4];
        t_byte x8 [4];
        t_byte m [4];
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k]  = sr_out[127-8*(4*c+k) -: 8];
                x2[k] = xtime(a[k]);
                x4[k] = xtime(x2[k]);
                x8[k] = xtime(x4[k]);
            end
            for (int r = 0; r < 4; r++) begin
                if (i_decrypt) begin
                    m[r] = (x8[r]^x4[r]^x2[r])
                         ^ (x8[(r+1)%4]^x2[(r+1)%4]^a[(r+1)%4])
                         ^ (x8[(r+2)%4]^x4[(r+2)%4]^a[(r+2)%4])
                         ^ (x8[(r+3)%4]^a[(r+3)%4]);
                end else begin
                    m[r] = x2[r] ^ (x2[(r+1)%4]^a[(r+1)%4]) ^ a[(r+2)%4] ^ a[(r+3)%4];
                end
            end
            for (int r = 0; r < 4; r++) begin
                mc_out[127-8*(4*c+r) -: 8] = m[r];
            end
        end
    end

    // forward: key after mix; inverse: key before mix
    always_comb begin
        if (!i_mix) begin
            o_state = sr_out ^ i_key;
        end else if (i_decrypt) begin
            o_state = inv_mix_of(sr_out ^ i_key);
        end else begin
            o_state = mc_out ^ i_key;
        end
    end

endmodule
`default_nettype wire

@@ hdl/aes_key_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// AES round-key store
// Round-key memory, one 128-bit round key per row, registered read port.
// ----------------------------------------------------------------------------
module aes_key_store
    import aes_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_we,
    input  wire  [1:0]          i_wsel,
    input  wire  [RoundW-1:0]   i_wrow,
    input  wire  [31:0]         i_wdata,
    input  wire  [RoundW-1:0]   i_rrow,
    output logic [127:0]        o_rdata
);

    logic [31:0] mem0 [MaxRounds+1];
    logic [31:0] mem1 [MaxRounds+1];
    logic [31:0] mem2 [MaxRounds+1];
    logic [31:0] mem3 [MaxRounds+1];

    // write one word a cycle while i_we is high, read a whole row
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            unique case (i_wsel)
                2'd0: mem0[i_wrow] <= i_wdata;
                2'd1: mem1[i_wrow] <= i_wdata;
                2'd2: mem2[i_wrow] <= i_wdata;
                2'd3: mem3[i_wrow] <= i_wdata;
                default: ;
            endcase
        end
        o_rdata <= {mem0[i_rrow], mem1[i_rrow], mem2[i_rrow], mem3[i_rrow]};
    end

endmodule
`default_nettype wire
